// ===== rtl/hca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hca_pkg
// Shared types and codes for the heightmap corner average block: request and
// result payloads, the microcode control word and its field codes.
// ----------------------------------------------------------------------------
package hca_pkg;

    // fixed field widths
    localparam int TILE_W    = 12;
    localparam int FIELD_H_W = 16;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int STEP_W    = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

    // request kinds
    localparam logic REQ_WRITE   = 1'b0;
    localparam logic REQ_CORNERS = 1'b1;

    // result status
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // jump conditions
    localparam logic [2:0] JC_NEXT   = 3'd0;
    localparam logic [2:0] JC_ALWAYS = 3'd1;
    localparam logic [2:0] JC_IDLE   = 3'd2;
    localparam logic [2:0] JC_OOR    = 3'd3;
    localparam logic [2:0] JC_WRITE  = 3'd4;
    localparam logic [2:0] JC_LOOP   = 3'd5;

    // neighbor offsets along one axis
    localparam logic [1:0] OFS_ZERO  = 2'd0;
    localparam logic [1:0] OFS_PLUS  = 2'd1;
    localparam logic [1:0] OFS_MINUS = 2'd2;

    // neighbor presence bits
    localparam logic [3:0] NEED_BELOW = 4'b0001;
    localparam logic [3:0] NEED_ABOVE = 4'b0010;
    localparam logic [3:0] NEED_LEFT  = 4'b0100;
    localparam logic [3:0] NEED_RIGHT = 4'b1000;

    // corner masks and corner numbers
    localparam logic [3:0] CM_BL = 4'b0001;
    localparam logic [3:0] CM_AL = 4'b0010;
    localparam logic [3:0] CM_AR = 4'b0100;
    localparam logic [3:0] CM_BR = 4'b1000;

    localparam logic [1:0] CORNER_BL = 2'd0;
    localparam logic [1:0] CORNER_AL = 2'd1;
    localparam logic [1:0] CORNER_AR = 2'd2;
    localparam logic [1:0] CORNER_BR = 2'd3;

    // result kinds issued by a finishing step
    localparam logic [1:0] FIN_NONE  = 2'd0;
    localparam logic [1:0] FIN_OK    = 2'd1;
    localparam logic [1:0] FIN_WRITE = 2'd2;
    localparam logic [1:0] FIN_ERR   = 2'd3;

    typedef struct packed {
        logic                        req_type;
        logic [TILE_W-1:0]           tile_index;
        logic signed [FIELD_H_W-1:0] height_value;
    } hca_req_t;

    typedef struct packed {
        logic                        status;
        logic signed [FIELD_H_W-1:0] corner_below_left;
        logic signed [FIELD_H_W-1:0] corner_above_left;
        logic signed [FIELD_H_W-1:0] corner_above_right;
        logic signed [FIELD_H_W-1:0] corner_below_right;
    } hca_res_t;

    typedef struct packed {
        logic [2:0]        jc;
        logic [STEP_W-1:0] target;
        logic              div_init;
        logic              div_step;
        logic              rd;
        logic [1:0]        dx;
        logic [1:0]        dy;
        logic [3:0]        need;
        logic [3:0]        add;
        logic              cdiv;
        logic [1:0]        corner;
        logic [1:0]        fin;
        logic              mem_wr;
    } hca_uword_t;

    typedef struct packed {
        logic oor;
        logic is_write;
        logic div_more;
    } hca_cond_t;

endpackage

// ===== rtl/hca_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hca_store
// Height memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hca_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/hca_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hca_div
// Two-stage divider of a signed corner sum by a count of 1 to 4, truncating
// toward zero; divide by three is a reciprocal multiply with one correction.
// ----------------------------------------------------------------------------
module hca_div import hca_pkg::*; #(
    parameter int HB = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 launch,
    input  logic signed [HB+1:0] sum,
    input  logic [2:0]           cnt,
    input  logic [1:0]           idx,
    output logic                 done,
    output logic [1:0]           done_idx,
    output logic [HB-1:0]        quot
);

    localparam int SW = HB + 2;
    localparam logic [SW-1:0] RECIP = SW'((64'd1 << SW) / 3);

    logic            s1_v_reg;
    logic            s1_neg_reg;
    logic [SW-1:0]   s1_mag_reg;
    logic [2:0]      s1_cnt_reg;
    logic [1:0]      s1_idx_reg;
    logic [2*SW-1:0] s1_prod_reg;
    logic            s2_v_reg;
    logic [1:0]      s2_idx_reg;
    logic [HB-1:0]   s2_quot_reg;

    logic [SW-1:0]   mag;
    logic [SW-1:0]   q0;
    logic [SW+1:0]   rem3;
    logic [SW-1:0]   q;
    logic [SW-1:0]   q_signed;

    assign mag = (sum < 0) ? SW'(-sum) : SW'(sum);

    always_ff @(posedge clk)
    begin
        s1_neg_reg  <= sum < 0;
        s1_mag_reg  <= mag;
        s1_cnt_reg  <= cnt;
        s1_idx_reg  <= idx;
        s1_prod_reg <= (2*SW)'(mag) * (2*SW)'(RECIP);
    end

    // quotient by count, magnitude first
    always_comb
    begin
        q0   = s1_prod_reg[2*SW-1:SW];
        rem3 = (SW+2)'(s1_mag_reg) - ((SW+2)'(q0) + ((SW+2)'(q0) << 1));
        unique case (s1_cnt_reg)
            3'd2:    q = s1_mag_reg >> 1;
            3'd3:    q = (rem3 >= (SW+2)'(3)) ? q0 + SW'(1) : q0;
            3'd4:    q = s1_mag_reg >> 2;
            default: q = s1_mag_reg;
        endcase
        q_signed = s1_neg_reg ? SW'(-q) : q;
    end

    always_ff @(posedge clk)
    begin
        s2_idx_reg  <= s1_idx_reg;
        s2_quot_reg <= q_signed[HB-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= launch;
            s2_v_reg <= s1_v_reg;
        end
    end

    assign done     = s2_v_reg;
    assign done_idx = s2_idx_reg;
    assign quot     = s2_quot_reg;

endmodule

// ===== rtl/hca_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hca_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module hca_seq import hca_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  hca_cond_t  cond,
    output hca_uword_t ctl,
    output logic       busy
);

    localparam logic [STEP_W-1:0] ST_IDLE      = 5'd0;
    localparam logic [STEP_W-1:0] ST_CHK_RANGE = 5'd1;
    localparam logic [STEP_W-1:0] ST_CHK_KIND  = 5'd2;
    localparam logic [STEP_W-1:0] ST_DIV       = 5'd3;
    localparam logic [STEP_W-1:0] ST_RD_C      = 5'd4;
    localparam logic [STEP_W-1:0] ST_RD_B      = 5'd5;
    localparam logic [STEP_W-1:0] ST_RD_A      = 5'd6;
    localparam logic [STEP_W-1:0] ST_RD_L      = 5'd7;
    localparam logic [STEP_W-1:0] ST_RD_LA     = 5'd8;
    localparam logic [STEP_W-1:0] ST_RD_LB     = 5'd9;
    localparam logic [STEP_W-1:0] ST_RD_R      = 5'd10;
    localparam logic [STEP_W-1:0] ST_RD_RA     = 5'd11;
    localparam logic [STEP_W-1:0] ST_RD_RB     = 5'd12;
    localparam logic [STEP_W-1:0] ST_DRAIN     = 5'd13;
    localparam logic [STEP_W-1:0] ST_CD0       = 5'd14;
    localparam logic [STEP_W-1:0] ST_CD1       = 5'd15;
    localparam logic [STEP_W-1:0] ST_CD2       = 5'd16;
    localparam logic [STEP_W-1:0] ST_CD3       = 5'd17;
    localparam logic [STEP_W-1:0] ST_WAIT0     = 5'd18;
    localparam logic [STEP_W-1:0] ST_WAIT1     = 5'd19;
    localparam logic [STEP_W-1:0] ST_FIN       = 5'd20;
    localparam logic [STEP_W-1:0] ST_WRITE     = 5'd21;
    localparam logic [STEP_W-1:0] ST_ERR       = 5'd22;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    // control store
    function automatic hca_uword_t ucode(input logic [STEP_W-1:0] step);
        hca_uword_t u;
        u = '0;
        unique case (step)
            ST_IDLE:
            begin
                u.jc     = JC_IDLE;
                u.target = ST_IDLE;
            end
            ST_CHK_RANGE:
            begin
                u.jc     = JC_OOR;
                u.target = ST_ERR;
            end
            ST_CHK_KIND:
            begin
                u.jc       = JC_WRITE;
                u.target   = ST_WRITE;
                u.div_init = 1'b1;
            end
            ST_DIV:
            begin
                u.jc       = JC_LOOP;
                u.target   = ST_DIV;
                u.div_step = 1'b1;
            end
            ST_RD_C:
            begin
                u.rd  = 1'b1;
                u.add = CM_BL | CM_AL | CM_AR | CM_BR;
            end
            ST_RD_B:
            begin
                u.rd   = 1'b1;
                u.dy   = OFS_MINUS;
                u.need = NEED_BELOW;
                u.add  = CM_BL | CM_BR;
            end
            ST_RD_A:
            begin
                u.rd   = 1'b1;
                u.dy   = OFS_PLUS;
                u.need = NEED_ABOVE;
                u.add  = CM_AL | CM_AR;
            end
            ST_RD_L:
            begin
                u.rd   = 1'b1;
                u.dx   = OFS_MINUS;
                u.need = NEED_LEFT;
                u.add  = CM_BL | CM_AL;
            end
            ST_RD_LA:
            begin
                u.rd   = 1'b1;
                u.dx   = OFS_MINUS;
                u.dy   = OFS_PLUS;
                u.need = NEED_LEFT | NEED_ABOVE;
                u.add  = CM_AL;
            end
            ST_RD_LB:
            begin
                u.rd   = 1'b1;
                u.dx   = OFS_MINUS;
                u.dy   = OFS_MINUS;
                u.need = NEED_LEFT | NEED_BELOW;
                u.add  = CM_BL;
            end
            ST_RD_R:
            begin
                u.rd   = 1'b1;
                u.dx   = OFS_PLUS;
                u.need = NEED_RIGHT;
                u.add  = CM_AR | CM_BR;
            end
            ST_RD_RA:
            begin
                u.rd   = 1'b1;
                u.dx   = OFS_PLUS;
                u.dy   = OFS_PLUS;
                u.need = NEED_RIGHT | NEED_ABOVE;
                u.add  = CM_AR;
            end
            ST_RD_RB:
            begin
                u.rd   = 1'b1;
                u.dx   = OFS_PLUS;
                u.dy   = OFS_MINUS;
                u.need = NEED_RIGHT | NEED_BELOW;
                u.add  = CM_BR;
            end
            ST_DRAIN:
            begin
                u.jc = JC_NEXT;
            end
            ST_CD0:
            begin
                u.cdiv   = 1'b1;
                u.corner = CORNER_BL;
            end
            ST_CD1:
            begin
                u.cdiv   = 1'b1;
                u.corner = CORNER_AL;
            end
            ST_CD2:
            begin
                u.cdiv   = 1'b1;
                u.corner = CORNER_AR;
            end
            ST_CD3:
            begin
                u.cdiv   = 1'b1;
                u.corner = CORNER_BR;
            end
            ST_WAIT0, ST_WAIT1:
            begin
                u.jc = JC_NEXT;
            end
            ST_FIN:
            begin
                u.jc     = JC_ALWAYS;
                u.target = ST_IDLE;
                u.fin    = FIN_OK;
            end
            ST_WRITE:
            begin
                u.jc     = JC_ALWAYS;
                u.target = ST_IDLE;
                u.fin    = FIN_WRITE;
                u.mem_wr = 1'b1;
            end
            ST_ERR:
            begin
                u.jc     = JC_ALWAYS;
                u.target = ST_IDLE;
                u.fin    = FIN_ERR;
            end
            default:
            begin
                u.jc     = JC_ALWAYS;
                u.target = ST_IDLE;
            end
        endcase
        return u;
    endfunction

    assign ctl  = ucode(step_reg);
    assign busy = step_reg != ST_IDLE;

    always_comb
    begin
        unique case (ctl.jc)
            JC_NEXT:   step_next = step_reg + STEP_W'(1);
            JC_ALWAYS: step_next = ctl.target;
            JC_IDLE:   step_next = start ? step_reg + STEP_W'(1) : ctl.target;
            JC_OOR:    step_next = cond.oor ? ctl.target : step_reg + STEP_W'(1);
            JC_WRITE:  step_next = cond.is_write ? ctl.target : step_reg + STEP_W'(1);
            JC_LOOP:   step_next = cond.div_more ? ctl.target : step_reg + STEP_W'(1);
            default:   step_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== rtl/heightmap_corner_average.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_corner_average
// Tile height grid with 2x2 box averaged corner heights, run by a microcoded
// sequencer over one height memory and a shared small-count divider.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+----------------------------
//  request   | in        | start high, busy low | request (hca_req_t)
//  result    | out       | done, one cycle      | result  (hca_res_t)
//  config    | in        | cfg_we               | cfg_index, cfg_data
//
//  write request: busy through the range check, the kind check and the write
//  out-of-grid request: busy through the range check and the error result
//  corner request: busy through the range and kind checks, the row/column
//  division loop (one quotient bit a cycle), nine reads through the single
//  memory read port and the two-stage divider
//  done pulses in the same cycle that busy first reads low; a new request can be taken then
//  the receiver cannot stall: a result is valid for its one cycle only
//  reset clears the sequencer and the grid size (64 by 64); the height
//  memory is not cleared and holds garbage until written
//
module heightmap_corner_average import hca_pkg::*; #(
    parameter int MAX_SIDE    = 64,
    parameter int HEIGHT_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  hca_req_t             request,
    output logic                 done,
    output hca_res_t             result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int HB     = HEIGHT_BITS;
    localparam int SW     = HB + 2;
    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int AW     = $clog2(DEPTH);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int ROW_W  = $clog2(MAX_SIDE);
    localparam int CW     = $clog2(ROW_W + 1);

    // configuration
    logic [CFG_W-1:0] grid_width_reg;
    logic [CFG_W-1:0] grid_height_reg;
    logic [SIDE_W-1:0] side_w;
    logic [SIDE_W-1:0] side_h;
    logic [2*SIDE_W-1:0] total;

    // request and sequencer
    hca_req_t   req_reg;
    hca_uword_t ctl;
    hca_cond_t  cond;
    logic       accept;

    // row / column split of the tile index
    logic [AW-1:0]    rem_reg;
    logic [AW:0]      dsr_reg;
    logic [ROW_W-1:0] row_reg;
    logic [CW-1:0]    div_cnt_reg;
    logic             div_ge;

    // neighbor flags: {right, left, above, below}
    logic [3:0] flags;
    logic       rd_ok;

    // memory access
    logic [AW-1:0] t_a;
    logic [AW-1:0] w_a;
    logic [AW-1:0] row_base;
    logic [AW-1:0] rd_addr;
    logic [HB-1:0] rd_data;
    logic signed [SW-1:0] rd_ext;

    // accumulation
    logic [3:0]           acc_mask_reg;
    logic [3:0]           acc_mask_next;
    logic signed [SW-1:0] sum_reg [4];
    logic [2:0]           cnt_reg [4];

    // corner division
    logic          cd_done;
    logic [1:0]    cd_idx;
    logic [HB-1:0] cd_quot;
    logic [HB-1:0] corner_reg [4];

    // result
    hca_res_t res_next;
    hca_res_t result_reg;
    logic     done_reg;

    // ------------------------------------------------------------------------
    // config registers, clamped to 1..MAX_SIDE on use
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= CFG_W'(64);
            grid_height_reg <= CFG_W'(64);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_GRID_WIDTH)
            begin
                grid_width_reg <= cfg_data;
            end
            else if (cfg_index == CFG_GRID_HEIGHT)
            begin
                grid_height_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        if (grid_width_reg == '0)
            side_w = SIDE_W'(1);
        else if (32'(grid_width_reg) > MAX_SIDE)
            side_w = SIDE_W'(MAX_SIDE);
        else
            side_w = SIDE_W'(grid_width_reg);

        if (grid_height_reg == '0)
            side_h = SIDE_W'(1);
        else if (32'(grid_height_reg) > MAX_SIDE)
            side_h = SIDE_W'(MAX_SIDE);
        else
            side_h = SIDE_W'(grid_height_reg);
    end

    assign total = (2*SIDE_W)'(side_w) * (2*SIDE_W)'(side_h);

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    assign accept = start && !busy;

    assign cond.oor      = 32'(req_reg.tile_index) >= 32'(total);
    assign cond.is_write = req_reg.req_type == REQ_WRITE;
    assign cond.div_more = div_cnt_reg != CW'(1);

    hca_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cond  (cond),
        .ctl   (ctl),
        .busy  (busy)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
    end

    // ------------------------------------------------------------------------
    // restoring division of the tile index by the row width, one bit a step:
    // quotient is the row, remainder the column
    // ------------------------------------------------------------------------
    assign div_ge = {1'b0, rem_reg} >= dsr_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.div_init)
        begin
            rem_reg     <= AW'(req_reg.tile_index);
            dsr_reg     <= (AW+1)'(side_w) << (ROW_W - 1);
            row_reg     <= '0;
            div_cnt_reg <= CW'(ROW_W);
        end
        else if (ctl.div_step)
        begin
            if (div_ge)
            begin
                rem_reg <= rem_reg - dsr_reg[AW-1:0];
            end
            dsr_reg     <= dsr_reg >> 1;
            row_reg     <= ROW_W'({row_reg, div_ge});
            div_cnt_reg <= div_cnt_reg - CW'(1);
        end
    end

    assign flags[0] = row_reg != '0;
    assign flags[1] = SIDE_W'(row_reg) != side_h - SIDE_W'(1);
    assign flags[2] = rem_reg != '0;
    assign flags[3] = rem_reg != AW'(side_w - SIDE_W'(1));

    // a read is skipped when a neighbor it needs lies off the grid
    assign rd_ok = ctl.rd && ((ctl.need & ~flags) == 4'b0000);

    // ------------------------------------------------------------------------
    // neighbor address and height memory
    // ------------------------------------------------------------------------
    assign t_a = AW'(req_reg.tile_index);
    assign w_a = AW'(side_w);

    always_comb
    begin
        unique case (ctl.dy)
            OFS_PLUS:  row_base = t_a + w_a;
            OFS_MINUS: row_base = t_a - w_a;
            default:   row_base = t_a;
        endcase
        unique case (ctl.dx)
            OFS_PLUS:  rd_addr = row_base + AW'(1);
            OFS_MINUS: rd_addr = row_base - AW'(1);
            default:   rd_addr = row_base;
        endcase
    end

    hca_store #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (HB)
    ) u_store (
        .clk   (clk),
        .we    (ctl.mem_wr),
        .waddr (t_a),
        .wdata (HB'(req_reg.height_value)),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // ------------------------------------------------------------------------
    // accumulate read data into the corners named by the previous step
    // ------------------------------------------------------------------------
    assign rd_ext        = SW'(signed'(rd_data));
    assign acc_mask_next = rd_ok ? ctl.add : 4'b0000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_mask_reg <= 4'b0000;
        end
        else
        begin
            acc_mask_reg <= acc_mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (ctl.div_init)
            begin
                sum_reg[k] <= '0;
                cnt_reg[k] <= '0;
            end
            else if (acc_mask_reg[k])
            begin
                sum_reg[k] <= sum_reg[k] + rd_ext;
                cnt_reg[k] <= cnt_reg[k] + 3'd1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // corner averages, one corner launched per step
    // ------------------------------------------------------------------------
    hca_div #(
        .HB (HB)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .launch   (ctl.cdiv),
        .sum      (sum_reg[ctl.corner]),
        .cnt      (cnt_reg[ctl.corner]),
        .idx      (ctl.corner),
        .done     (cd_done),
        .done_idx (cd_idx),
        .quot     (cd_quot)
    );

    always_ff @(posedge clk)
    begin
        if (cd_done)
        begin
            corner_reg[cd_idx] <= cd_quot;
        end
    end

    // ------------------------------------------------------------------------
    // result register: writes and out-of-grid requests return zero corners
    // ------------------------------------------------------------------------
    always_comb
    begin
        res_next = '0;
        unique case (ctl.fin)
            FIN_OK:
            begin
                res_next.status             = STATUS_OK;
                res_next.corner_below_left  = FIELD_H_W'(corner_reg[CORNER_BL]);
                res_next.corner_above_left  = FIELD_H_W'(corner_reg[CORNER_AL]);
                res_next.corner_above_right = FIELD_H_W'(corner_reg[CORNER_AR]);
                res_next.corner_below_right = FIELD_H_W'(corner_reg[CORNER_BR]);
            end
            FIN_ERR:
            begin
                res_next.status = STATUS_RANGE;
            end
            default:
            begin
                res_next.status = STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.fin != FIN_NONE)
        begin
            result_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.fin != FIN_NONE;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_done_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(ctl.fin != FIN_NONE))
        else $error("result strobe without a finishing step");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == STATUS_RANGE) |->
            (result.corner_below_left == '0 && result.corner_above_left == '0 &&
             result.corner_above_right == '0 && result.corner_below_right == '0))
        else $error("out-of-grid result with nonzero corners");

    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.cdiv |-> (cnt_reg[ctl.corner] >= 3'd1 && cnt_reg[ctl.corner] <= 3'd4))
        else $error("corner count outside 1..4 at division");

    a_wr_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.mem_wr |-> !cond.oor)
        else $error("height write outside the grid");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted request did not make the block busy");

endmodule

// ===== dv/heightmap_corner_average_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_corner_average_tb
// Self-checking bench for the tile height grid. Height writes and corner
// requests go through the start/busy port. A local mirror of the height grid
// and of the grid size predicts every result, and each done pulse is checked
// against the oldest prediction. The run steps through several grid sizes:
// the extremes, values that clamp, and small random shapes.
// ----------------------------------------------------------------------------
module heightmap_corner_average_tb;
    import hca_pkg::*;

    localparam int GRID_CELLS = 4096;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    hca_req_t             request;
    logic                 done;
    hca_res_t             result;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // requests waiting for the driver, predicted results waiting for done
    hca_req_t pending_requests[$];
    hca_res_t expected_results[$];

    // mirror of the block: height grid and raw grid size registers
    logic signed [FIELD_H_W-1:0] height_mirror [GRID_CELLS];
    logic [CFG_W-1:0]            mirror_width;
    logic [CFG_W-1:0]            mirror_height;

    // stimulus side view of the grid: which cells have been written so far
    bit gen_written [GRID_CELLS];
    int gen_w;
    int gen_h;
    int gen_total;
    int queued_items;

    int error_count;
    bit req_taken;
    int gap_left;
    bit no_idle;

    heightmap_corner_average dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // a register value of 0 acts as 1, anything above 64 acts as 64
    function automatic int clamp_side(logic [CFG_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > 64)
            return 64;
        return int'(raw);
    endfunction

    // expected result of one accepted request; an in-grid write updates the mirror
    function automatic hca_res_t predict_corners(hca_req_t rq);
        hca_res_t res;
        int w;
        int h;
        int t;
        int row;
        int col;
        int dx;
        int dy;
        int k;
        int v;
        int sum[4];
        int cnt[4];
        res = '0;
        w = clamp_side(mirror_width);
        h = clamp_side(mirror_height);
        t = int'(rq.tile_index);
        if (t >= w * h)
        begin
            res.status = STATUS_RANGE;
            return res;
        end
        res.status = STATUS_OK;
        if (rq.req_type == REQ_WRITE)
        begin
            height_mirror[t] = rq.height_value;
            return res;
        end
        row = t / w;
        col = t % w;
        for (k = 0; k < 4; k++)
        begin
            sum[k] = 0;
            cnt[k] = 0;
        end
        // walk the 3x3 box; each in-grid cell feeds the corners it touches
        for (dy = -1; dy <= 1; dy++)
        begin
            for (dx = -1; dx <= 1; dx++)
            begin
                if (row + dy >= 0 && row + dy < h && col + dx >= 0 && col + dx < w)
                begin
                    v = int'(height_mirror[(row + dy) * w + col + dx]);
                    if (dx <= 0 && dy <= 0)
                    begin
                        sum[CORNER_BL] += v;
                        cnt[CORNER_BL]++;
                    end
                    if (dx <= 0 && dy >= 0)
                    begin
                        sum[CORNER_AL] += v;
                        cnt[CORNER_AL]++;
                    end
                    if (dx >= 0 && dy >= 0)
                    begin
                        sum[CORNER_AR] += v;
                        cnt[CORNER_AR]++;
                    end
                    if (dx >= 0 && dy <= 0)
                    begin
                        sum[CORNER_BR] += v;
                        cnt[CORNER_BR]++;
                    end
                end
            end
        end
        // integer division truncates toward zero, as the block does
        res.corner_below_left  = FIELD_H_W'(sum[CORNER_BL] / cnt[CORNER_BL]);
        res.corner_above_left  = FIELD_H_W'(sum[CORNER_AL] / cnt[CORNER_AL]);
        res.corner_above_right = FIELD_H_W'(sum[CORNER_AR] / cnt[CORNER_AR]);
        res.corner_below_right = FIELD_H_W'(sum[CORNER_BR] / cnt[CORNER_BR]);
        return res;
    endfunction

    task automatic flag_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // sender gaps: mostly none, some short, a few long; none at all in bursts
    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [FIELD_H_W-1:0] rand_height();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return FIELD_H_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // driver: a request stays on the port until start meets busy low
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || req_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_requests.size() > 0)
            begin
                start   <= 1'b1;
                request <= pending_requests.pop_front();
                gap_left = next_gap();
                if ($urandom_range(0, 39) == 0)
                    no_idle = !no_idle;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks done pulses, tracks register writes, predicts each
    // accepted request; all sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        req_taken = 1'b0;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    flag_mismatch("result with no request outstanding");
                end
                else
                begin
                    hca_res_t want;
                    want = expected_results.pop_front();
                    if (result.status !== want.status)
                        flag_mismatch($sformatf("status got %0b want %0b",
                                                result.status, want.status));
                    if (result.corner_below_left !== want.corner_below_left)
                        flag_mismatch($sformatf("below-left got %0d want %0d",
                            result.corner_below_left, want.corner_below_left));
                    if (result.corner_above_left !== want.corner_above_left)
                        flag_mismatch($sformatf("above-left got %0d want %0d",
                            result.corner_above_left, want.corner_above_left));
                    if (result.corner_above_right !== want.corner_above_right)
                        flag_mismatch($sformatf("above-right got %0d want %0d",
                            result.corner_above_right, want.corner_above_right));
                    if (result.corner_below_right !== want.corner_below_right)
                        flag_mismatch($sformatf("below-right got %0d want %0d",
                            result.corner_below_right, want.corner_below_right));
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_GRID_WIDTH)
                    mirror_width = cfg_data;
                else if (cfg_index == CFG_GRID_HEIGHT)
                    mirror_height = cfg_data;
            end
            req_taken = start && !busy;
            if (req_taken)
                expected_results.insert(expected_results.size(), predict_corners(request));
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_request(logic kind, int idx, logic signed [FIELD_H_W-1:0] hv);
        hca_req_t rq;
        rq.req_type     = kind;
        rq.tile_index   = TILE_W'(idx);
        rq.height_value = hv;
        pending_requests.insert(pending_requests.size(), rq);
        queued_items++;
        // writes outside the grid are dropped by the block
        if (kind == REQ_WRITE && idx < gen_total)
            gen_written[idx] = 1'b1;
    endtask

    // corner request; any cell of the 3x3 box never written gets a height first
    task automatic queue_corner(int t);
        int row;
        int col;
        int dx;
        int dy;
        int nb;
        if (t < gen_total)
        begin
            row = t / gen_w;
            col = t % gen_w;
            for (dy = -1; dy <= 1; dy++)
            begin
                for (dx = -1; dx <= 1; dx++)
                begin
                    if (row + dy >= 0 && row + dy < gen_h &&
                        col + dx >= 0 && col + dx < gen_w)
                    begin
                        nb = (row + dy) * gen_w + col + dx;
                        if (!gen_written[nb])
                            push_request(REQ_WRITE, nb, rand_height());
                    end
                end
            end
        end
        push_request(REQ_CORNERS, t, FIELD_H_W'($urandom));
    endtask

    // wait until the block has answered everything and is idle again
    task automatic wait_drain();
        while (pending_requests.size() > 0 || start || expected_results.size() > 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_grid_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // new grid size, only while the block is idle
    task automatic set_grid(logic [CFG_W-1:0] w_raw, logic [CFG_W-1:0] h_raw);
        wait_drain();
        write_grid_reg(CFG_GRID_WIDTH, w_raw);
        write_grid_reg(CFG_GRID_HEIGHT, h_raw);
        gen_w     = clamp_side(w_raw);
        gen_h     = clamp_side(h_raw);
        gen_total = gen_w * gen_h;
    endtask

    task automatic run_phase(logic [CFG_W-1:0] w_raw, logic [CFG_W-1:0] h_raw, int n);
        int goal;
        int r;
        int t;
        set_grid(w_raw, h_raw);
        goal = queued_items + n;
        while (queued_items < goal)
        begin
            r = $urandom_range(0, 99);
            if (r < 50 || (r >= 75 && r < 90 && gen_total == GRID_CELLS))
            begin
                queue_corner($urandom_range(0, gen_total - 1));
            end
            else if (r < 75)
            begin
                push_request(REQ_WRITE, $urandom_range(0, gen_total - 1), rand_height());
            end
            else if (r < 90)
            begin
                // outside the grid: either kind, any index up to the top
                push_request(logic'($urandom_range(0, 1)),
                             $urandom_range(gen_total, GRID_CELLS - 1),
                             FIELD_H_W'($urandom));
            end
            else
            begin
                // tiles on the grid border, where neighbors go missing
                case ($urandom_range(0, 3))
                    0: t = $urandom_range(0, gen_h - 1) * gen_w;
                    1: t = $urandom_range(0, gen_h - 1) * gen_w + gen_w - 1;
                    2: t = $urandom_range(0, gen_w - 1);
                    default: t = (gen_h - 1) * gen_w + $urandom_range(0, gen_w - 1);
                endcase
                queue_corner(t);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        request       = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        mirror_width  = 7'd64;
        mirror_height = 7'd64;
        error_count   = 0;
        queued_items  = 0;
        gap_left      = 0;
        no_idle       = 1'b0;
        req_taken     = 1'b0;
        gen_w         = 64;
        gen_h         = 64;
        gen_total     = GRID_CELLS;
        foreach (height_mirror[i])
            height_mirror[i] = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset grid 64 x 64: bottom-left grid corner, most-negative heights but
        // one; the above-right average truncates toward zero
        push_request(REQ_WRITE, 0, 16'sh8000);
        push_request(REQ_WRITE, 1, 16'sh8000);
        push_request(REQ_WRITE, 64, 16'sh8000);
        push_request(REQ_WRITE, 65, 16'sh8001);
        queue_corner(0);
        // top-right grid corner, most-positive heights, last index
        push_request(REQ_WRITE, 4095, 16'sh7fff);
        push_request(REQ_WRITE, 4094, 16'sh7fff);
        push_request(REQ_WRITE, 4031, 16'sh7fff);
        push_request(REQ_WRITE, 4030, 16'sh7ffe);
        queue_corner(4095);

        // width 0 acts as 1, height 127 acts as 64: a single column
        set_grid(7'd0, 7'd127);
        queue_corner(0);
        queue_corner(63);
        push_request(REQ_WRITE, 64, 16'shffff);
        push_request(REQ_CORNERS, 4095, 16'sh0000);
        push_request(REQ_WRITE, 4095, 16'sh5a5a);

        // random part over a spread of grid shapes
        run_phase(7'd1, 7'd1, 110);
        run_phase(7'd64, 7'd1, 130);
        run_phase(7'd0, 7'd127, 130);
        run_phase(7'd127, 7'd100, 120);
        run_phase(7'd2, 7'd2, 130);
        run_phase(7'd3, 7'd7, 130);
        run_phase(7'd8, 7'd5, 130);
        repeat (4)
            run_phase(CFG_W'($urandom_range(0, 12)), CFG_W'($urandom_range(0, 12)), 130);
        run_phase(CFG_W'($urandom_range(13, 127)), CFG_W'($urandom_range(1, 9)), 130);

        wait_drain();
        repeat (40) @(negedge clk);
        if (error_count == 0)
        begin
            $display("heightmap_corner_average_tb: PASS");
        end
        else
        begin
            $display("heightmap_corner_average_tb: FAIL");
        end
        $finish;
    end

    // hard stop far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("heightmap_corner_average_tb: FAIL");
        $finish;
    end

endmodule

// ===== heightmap_corner_average.f =====
rtl/hca_pkg.sv
rtl/hca_store.sv
rtl/hca_div.sv
rtl/hca_seq.sv
rtl/heightmap_corner_average.sv
dv/heightmap_corner_average_tb.sv
